### rtl/core/box_blur_3x3_edge_aware_core_defines.svh
// Assertion macros for the box blur core checker.
// The macros expect aclk and aresetn to be visible where they are used.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bblur_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the 3x3 box blur core.
// No dependencies; all other core files but the macro header refer to this package.
package bblur_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int ROW_W      = FH_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = 12;
    localparam int NUM_W      = SUM_W + 1;
    localparam int CNT_W      = 4;
    localparam int RECIP_W    = 19;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W     = NUM_W + RECIP_W;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd768;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    // Which neighbours of the centre pixel lie inside the frame.
    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } nbr_mask_t;

    // ceil(2^19 / (2 * count)); exact floor division of a 13-bit numerator.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd1:    r = 19'd262144;
            4'd2:    r = 19'd131072;
            4'd3:    r = 19'd87382;
            4'd4:    r = 19'd65536;
            4'd5:    r = 19'd52429;
            4'd6:    r = 19'd43691;
            4'd7:    r = 19'd37450;
            4'd8:    r = 19'd32768;
            4'd9:    r = 19'd29128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/bblur_line_store.sv
`timescale 1ns / 1ps
// Line store memory: the two rows above the incoming row, one word per column.
// Depends on bblur_pkg for the pixel width.
module bblur_line_store #(
    parameter int DEPTH = bblur_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [2*bblur_pkg::PIX_W-1:0]  rd_data,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [2*bblur_pkg::PIX_W-1:0]  wr_data
);

    // Upper half holds the older row, lower half the newer row.
    logic [2*bblur_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/bblur_window.sv
`timescale 1ns / 1ps
// 3x3 neighbourhood window with masked per-colour sums and the divisor reciprocal.
// Depends on bblur_pkg for widths, the mask type and the reciprocal table.
module bblur_window (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   shift_en,
    input  bblur_pkg::pixel_t                      col_top,
    input  bblur_pkg::pixel_t                      col_mid,
    input  bblur_pkg::pixel_t                      col_bot,
    input  logic                                   sum_en,
    input  bblur_pkg::nbr_mask_t                   mask,
    output logic [2:0][bblur_pkg::NUM_W-1:0]       num,
    output logic [bblur_pkg::RECIP_W-1:0]          recip_out
);

    // Entry index is column * 3 + row; column 0 is the oldest, row 0 the top.
    bblur_pkg::pixel_t win_reg [9];
    bblur_pkg::pixel_t win_next [9];

    logic [8:0]                          tap_en;
    logic [2:0]                          col_en;
    logic [2:0]                          row_en;
    logic [2:0][bblur_pkg::SUM_W-1:0]    sum;
    logic [bblur_pkg::CNT_W-1:0]         count;
    logic [2:0][bblur_pkg::NUM_W-1:0]    num_reg;
    logic [bblur_pkg::RECIP_W-1:0]       recip_reg;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            win_next[k] = win_reg[k + 3];
        end
        win_next[6] = col_top;
        win_next[7] = col_mid;
        win_next[8] = col_bot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (shift_en) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    assign col_en = {mask.right, 1'b1, mask.left};
    assign row_en = {mask.bottom, 1'b1, mask.top};

    always_comb begin
        count = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                tap_en[c * 3 + r] = col_en[c] & row_en[r];
            end
        end
        for (int k = 0; k < 9; k++) begin
            count = count + bblur_pkg::CNT_W'(tap_en[k]);
        end
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int k = 0; k < 9; k++) begin
                if (tap_en[k]) begin
                    sum[ch] = sum[ch]
                        + bblur_pkg::SUM_W'(win_reg[k][bblur_pkg::CH_W*ch +: bblur_pkg::CH_W]);
                end
            end
        end
    end

    // Rounded mean numerator is 2 * sum + count; the divisor is 2 * count.
    always_ff @(posedge aclk) begin
        if (sum_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                num_reg[ch] <= {sum[ch], 1'b0} + bblur_pkg::NUM_W'(count);
            end
            recip_reg <= bblur_pkg::recip(count);
        end
    end

    assign num       = num_reg;
    assign recip_out = recip_reg;

endmodule

### rtl/core/bblur_mean.sv
`timescale 1ns / 1ps
// Division of the three numerators by reciprocal multiplication.
// Depends on bblur_pkg for widths and the reciprocal shift.
module bblur_mean (
    input  logic                                 aclk,
    input  logic                                 mul_en,
    input  logic [2:0][bblur_pkg::NUM_W-1:0]     num,
    input  logic [bblur_pkg::RECIP_W-1:0]        recip_in,
    output logic [2:0][bblur_pkg::CH_W-1:0]      quot
);

    logic [2:0][bblur_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                prod_reg[ch] <= bblur_pkg::PROD_W'(num[ch]) * bblur_pkg::PROD_W'(recip_in);
            end
        end
    end

    // The quotient never exceeds 255, so the bits above the byte are zero.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            quot[ch] = prod_reg[ch][bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
        end
    end

endmodule

### rtl/core/box_blur_3x3_edge_aware_core.sv
`timescale 1ns / 1ps
// Top level of the 3x3 edge-aware box blur core.
// Depends on bblur_pkg, bblur_line_store, bblur_window and bblur_mean.
//
// Usage. Pixels enter in raster order on the s_ channel (tuser low, colour in
// tdata). The block answers each position with the rounded mean of each colour
// over its 3x3 neighbourhood, skipping neighbours outside the frame, on the m_
// channel. The result for a position is produced by the transfer that arrives
// frame_width + 1 places later, so after the last pixel the source sends
// frame_width + 1 drain transfers (tuser high); the final result carries tlast,
// after which the counters return to zero and a new frame may start. A drain
// transfer sent before the frame is complete is absorbed without effect.
// Sequencing: one item is worked on at a time. An item that yields no result
// passes through the accept and then the line store read-modify-write. An item
// that yields a result passes through read, window update, sum, reciprocal
// multiply and the output register load, which raises m_tvalid. An ignored
// drain transfer is only accepted and starts no work.
// Reset (aresetn low, synchronous) clears the counters, the window and the
// output valid, and loads the register defaults (width 1024, height 768).
// If the receiver stalls, the result waits in the output register while the
// next item is taken in; that item stops before its own output load. The user must
// write frame width and height on the cfg_ port between frames; no check is made.
module box_blur_3x3_edge_aware_core #(
    parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bblur_pkg::PIX_W-1:0]        s_tdata,   // in_blue, in_green, in_red
    input  logic                               s_tuser,   // func
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bblur_pkg::PIX_W-1:0]        m_tdata,   // out_blue, out_green, out_red
    output logic                               m_tlast,   // frame_last
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int FW_W  = bblur_pkg::FW_W;
    localparam int FH_W  = bblur_pkg::FH_W;
    localparam int ROW_W = bblur_pkg::ROW_W;
    localparam int PIX_W = bblur_pkg::PIX_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SHIFT = 5'b00010,
        ST_SUM   = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers and their effective values.
    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;
    logic [CW-1:0]    eff_w;
    logic [FH_W-1:0]  eff_h;

    // Frame position counters.
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic [FH_W-1:0]  out_row_reg, out_row_next;

    logic             in_xfer;
    logic             item_take;
    logic             draining;
    bblur_pkg::pixel_t pix_reg;

    logic             emit;
    logic [CW:0]      in_col_inc;
    logic             in_col_wrap;
    logic [CW:0]      out_col_inc;
    logic             out_col_end;
    logic [FH_W:0]    out_row_inc;
    logic             out_row_end;

    bblur_pkg::nbr_mask_t mask_reg, mask_next;
    logic             last_reg;

    logic [2*PIX_W-1:0]                   ls_rd_data;
    logic                                 ls_wr_en;
    logic [2:0][bblur_pkg::NUM_W-1:0]     num;
    logic [bblur_pkg::RECIP_W-1:0]        recip_val;
    logic [2:0][bblur_pkg::CH_W-1:0]      quot;

    logic             out_load;
    logic             m_tvalid_reg;
    logic [PIX_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    // ------------------------------------------------------------------
    // Configuration. Writes are always taken; a width of zero behaves as
    // one and a width above the line store depth is clamped to it.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= bblur_pkg::FRAME_WIDTH_RESET;
            fh_reg <= bblur_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bblur_pkg::CFG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                bblur_pkg::CFG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (fw_reg == '0) begin
            eff_w = CW'(1);
        end else if (32'(fw_reg) > 32'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(fw_reg);
        end
        eff_h = (fh_reg == '0) ? FH_W'(1) : fh_reg;
    end

    // ------------------------------------------------------------------
    // Input side. Once every row has arrived the block is draining: any
    // transfer then acts as a drain tick and feeds a black pixel.
    // ------------------------------------------------------------------
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign draining  = (in_row_reg >= ROW_W'(eff_h));
    assign item_take = in_xfer && !((s_tuser == bblur_pkg::FUNC_DRAIN) && !draining);

    always_ff @(posedge aclk) begin
        if (item_take) begin
            pix_reg <= draining ? '0 : s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Line store. The read is issued with the transfer and the column is
    // written back in the following cycle. Only one item is in flight, so
    // the next read of the same column always sees the written data.
    // ------------------------------------------------------------------
    assign ls_wr_en = (state_reg == ST_SHIFT);

    bblur_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (item_take),
        .rd_addr (in_col_reg[AW-1:0]),
        .rd_data (ls_rd_data),
        .wr_en   (ls_wr_en),
        .wr_addr (in_col_reg[AW-1:0]),
        .wr_data ({ls_rd_data[PIX_W-1:0], pix_reg})
    );

    // ------------------------------------------------------------------
    // Position bookkeeping, evaluated in the window update cycle. The
    // result centred on the window's middle column is due once the input
    // is a row plus a pixel ahead. When the input has just wrapped to a
    // new row, the column that arrives belongs to the next row and is
    // left out of the neighbourhood.
    // ------------------------------------------------------------------
    always_comb begin
        emit = (in_row_reg >= ROW_W'(2)) || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

        in_col_inc  = {1'b0, in_col_reg} + (CW + 1)'(1);
        in_col_wrap = (in_col_inc >= {1'b0, eff_w});
        out_col_inc = {1'b0, out_col_reg} + (CW + 1)'(1);
        out_col_end = (out_col_inc >= {1'b0, eff_w});
        out_row_inc = {1'b0, out_row_reg} + (FH_W + 1)'(1);
        out_row_end = (out_row_inc >= {1'b0, eff_h});

        mask_next.left   = (out_col_reg != '0);
        mask_next.right  = (in_col_reg != '0) && !out_col_end;
        mask_next.top    = (out_row_reg != '0);
        mask_next.bottom = !out_row_end;
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (state_reg == ST_SHIFT) begin
            in_col_next = in_col_wrap ? '0 : in_col_inc[CW-1:0];
            in_row_next = in_col_wrap ? in_row_reg + ROW_W'(1) : in_row_reg;
            if (emit) begin
                if (out_row_end && out_col_end) begin
                    // Final position of the frame: start over.
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else begin
                    out_col_next = out_col_end ? '0 : out_col_inc[CW-1:0];
                    out_row_next = out_col_end ? out_row_inc[FH_W-1:0] : out_row_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SHIFT) begin
            mask_reg <= mask_next;
            last_reg <= out_row_end && out_col_end;
        end
    end

    // ------------------------------------------------------------------
    // Window, sums and division.
    // ------------------------------------------------------------------
    bblur_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (state_reg == ST_SHIFT),
        .col_top   (ls_rd_data[2*PIX_W-1:PIX_W]),
        .col_mid   (ls_rd_data[PIX_W-1:0]),
        .col_bot   (pix_reg),
        .sum_en    (state_reg == ST_SUM),
        .mask      (mask_reg),
        .num       (num),
        .recip_out (recip_val)
    );

    bblur_mean u_mean (
        .aclk     (aclk),
        .mul_en   (state_reg == ST_MUL),
        .num      (num),
        .recip_in (recip_val),
        .quot     (quot)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (item_take) state_next = ST_SHIFT;
            ST_SHIFT: state_next = emit ? ST_SUM : ST_IDLE;
            ST_SUM:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. A new result is loaded when the register is empty
    // or its current result is being transferred in the same cycle.
    // ------------------------------------------------------------------
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {quot[2], quot[1], quot[0]};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/core/bblur_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the box blur core, bound to the top level.
// Depends on the core's assertion macro header and on bblur_pkg.
`include "box_blur_3x3_edge_aware_core_defines.svh"

module bblur_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bblur_pkg::PIX_W-1:0]   m_tdata,
    input logic                          m_tlast
);

    // A stalled result keeps its value and its frame marker.
    `BB_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // A pixel transfer starts work on that item, so the input closes next cycle.
    `BB_ASSERT_NEXT(a_one_item_in_flight, s_tvalid && s_tready && (s_tuser == bblur_pkg::FUNC_PIXEL), !s_tready, "input accepted while an item is in flight")

    // The cycle after reset shows no result.
    `BB_ASSERT_SAME(a_no_result_after_reset, $past(!aresetn), !m_tvalid, "result valid straight after reset")

endmodule

bind box_blur_3x3_edge_aware_core bblur_checker u_bblur_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
